### design/e2q_pkg.sv
package e2q_pkg;

   // Fixed field widths of the request and response channels.
   localparam int ANGLE_W = 32;
   localparam int OUT_W   = 16;

   // One lane per Euler angle.
   localparam int LANES      = 3;
   localparam int LANE_PITCH = 0;
   localparam int LANE_YAW   = 1;
   localparam int LANE_ROLL  = 2;

   // Register stages in each part of the pipeline.
   localparam int LANE_STAGES  = 10;
   localparam int MERGE_STAGES = 5;
   localparam int PIPE_LATENCY = LANE_STAGES + MERGE_STAGES;

   // Degrees in a full and a half turn.
   localparam int DEG_TURN      = 360;
   localparam int DEG_HALF_TURN = 180;

   // Quarter turn in Q30 radians and the length of the sine series.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 10;

endpackage

### design/e2q_lane.sv
module e2q_lane #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int OUT_FRAC_BITS   = 15,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
   output logic                                out_valid,
   output logic signed [OUT_FRAC_BITS+1:0]     sin_val,
   output logic signed [OUT_FRAC_BITS+1:0]     cos_val
);
   import e2q_pkg::*;

   // Angle units in a full turn and the reciprocal used for the remainder.
   localparam longint unsigned TURN_UNITS = 64'(DEG_TURN) << ANGLE_FRAC_BITS;
   localparam int TW = $clog2(TURN_UNITS);
   localparam logic [TW-1:0] TURN_K = TW'(TURN_UNITS);
   localparam longint unsigned RECIP_TURN = (64'd1 << ANGLE_W) / TURN_UNITS;
   localparam int RCW = $clog2(RECIP_TURN + 1);
   localparam logic [RCW-1:0] RECIP_TURN_K = RCW'(RECIP_TURN);

   // Scaling of the remainder into half-angle phase steps.
   localparam int SCALE_SH = SINE_TABLE_BITS + 1;
   localparam int SHL = (SCALE_SH >= ANGLE_FRAC_BITS) ? SCALE_SH - ANGLE_FRAC_BITS : 0;
   localparam int SHR = (SCALE_SH >= ANGLE_FRAC_BITS) ? 0 : ANGLE_FRAC_BITS - SCALE_SH;
   localparam int WW = TW + SHL;
   localparam longint unsigned NUM_MAX =
      (64'(DEG_TURN) << SCALE_SH) + 64'(DEG_HALF_TURN);
   localparam int NW = $clog2(NUM_MAX + 1);
   localparam logic [NW-1:0] HALF_TURN_K = NW'(DEG_HALF_TURN);
   localparam logic [NW-1:0] DEG_K = NW'(DEG_TURN);
   localparam longint unsigned RECIP_DEG = (64'd1 << NW) / 64'(DEG_TURN);
   localparam int RDW = $clog2(RECIP_DEG + 1);
   localparam logic [RDW-1:0] RECIP_DEG_K = RDW'(RECIP_DEG);

   // Phase, table address and value widths.
   localparam int PW = SINE_TABLE_BITS + 2;
   localparam int AW = SINE_TABLE_BITS + 1;
   localparam int EVW = OUT_FRAC_BITS + 1;
   localparam int SVW = OUT_FRAC_BITS + 2;
   localparam int TABLE_DEPTH = (1 << SINE_TABLE_BITS) + 1;
   localparam logic [AW-1:0] QUARTER_K = AW'(1 << SINE_TABLE_BITS);
   localparam logic [PW-1:0] HALF_STEPS_K = PW'(1 << SCALE_SH);

   typedef logic [EVW-1:0] tab_entry_type;
   typedef tab_entry_type tab_type [TABLE_DEPTH];

   // Unsigned quotient by restoring long division.
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned part;
      quo  = '0;
      part = '0;
      for (int b = 63; b >= 0; b--) begin
         part = {part[62:0], num[b]};
         quo  = {quo[62:0], 1'b0};
         if (part >= den) begin
            part   = part - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine table, built at elaboration from a Q30 Taylor series.
   function automatic tab_type build_table();
      tab_type         tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned d;
      longint          sum;
      int              sh;
      sh = 30 - OUT_FRAC_BITS;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         x = (64'(k) * HALF_PI_Q30 + ((64'd1 << SINE_TABLE_BITS) >> 1)) >> SINE_TABLE_BITS;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            d = 64'(2 * n) * 64'(2 * n + 1);
            term = (term * x2 + (64'd1 << 29)) >> 30;
            term = udiv(term + (d >> 1), d);
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
         end
         if (sh > 0) begin
            sum = longint'((64'(sum) + (64'd1 << (sh - 1))) >> sh);
         end
         if (sum > (longint'(1) << OUT_FRAC_BITS)) begin
            sum = longint'(1) << OUT_FRAC_BITS;
         end
         tab[k] = EVW'(sum);
      end
      return tab;
   endfunction

   localparam tab_type SINE_TAB = build_table();

   logic [LANE_STAGES-1:0] valid_ff;
   logic [LANE_STAGES-1:0] valid_in;

   logic [ANGLE_W-1:0]     mag_in, mag1_ff, mag2_ff, mag3_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [ANGLE_W+RCW-1:0] quot_prod;
   logic [RCW-1:0]         quot_in, quot2_ff;
   logic [RCW+TW-1:0]      back_prod;
   logic [ANGLE_W-1:0]     back_in, back3_ff;
   logic [TW:0]            rem_est;
   logic [TW-1:0]          rem_in, rem4_ff;
   logic [WW-1:0]          scaled;
   logic [NW-1:0]          num_in, num5_ff;
   logic [NW+RDW-1:0]      step_prod;
   logic [RDW-1:0]         step_in, step5_ff;
   logic [NW-1:0]          step_rem;
   logic [PW-1:0]          pm_est_in, pm_est6_ff;
   logic                   carry_in, carry6_ff;
   logic [PW-1:0]          pm_sum;
   logic [PW-1:0]          phase_in, phase7_ff;
   logic [1:0]             sin_quad, cos_quad;
   logic [SINE_TABLE_BITS-1:0] phase_idx;
   logic [AW-1:0]          sin_addr_in, cos_addr_in, sin_addr8_ff, cos_addr8_ff;
   logic                   sin_neg8_ff, cos_neg8_ff, sin_neg9_ff, cos_neg9_ff;
   logic [EVW-1:0]         sin_mag9_ff, cos_mag9_ff;
   logic signed [SVW-1:0]  sin_in, cos_in, sin10_ff, cos10_ff;

   // Valid bits follow each transfer down the lane.
   assign valid_in = {valid_ff[LANE_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage one: magnitude and sign of the angle.
   assign mag_in = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);

   // Stage two: quotient estimate by the reciprocal of a full turn.
   assign quot_prod = mag1_ff * RECIP_TURN_K;
   assign quot_in   = quot_prod[ANGLE_W+RCW-1:ANGLE_W];

   // Stage three: the estimate times a full turn.
   assign back_prod = quot2_ff * TURN_K;
   assign back_in   = ANGLE_W'(back_prod);

   // Stage four: remainder, corrected once since the estimate is at most one short.
   assign rem_est = (TW+1)'(mag3_ff - back3_ff);
   assign rem_in  = (rem_est >= (TW+1)'(TURN_K)) ?
                    TW'(rem_est - (TW+1)'(TURN_K)) : TW'(rem_est);

   // Stage five: scale the remainder to phase steps and estimate the division by 360.
   assign scaled    = (WW'(rem4_ff) << SHL) >> SHR;
   assign num_in    = NW'(scaled) + HALF_TURN_K;
   assign step_prod = num_in * RECIP_DEG_K;
   assign step_in   = step_prod[NW+RDW-1:NW];

   // Stage six: check whether the step estimate falls one short.
   assign step_rem  = num5_ff - NW'(step5_ff * DEG_K);
   assign carry_in  = (step_rem >= DEG_K);
   assign pm_est_in = PW'(step5_ff);

   // Stage seven: rounded phase magnitude, signed and wrapped to a full turn.
   assign pm_sum   = pm_est6_ff + PW'(carry6_ff);
   assign phase_in = neg6_ff ? PW'(-pm_sum) : pm_sum;

   // Stage eight: quadrant folding; the cosine sits one quadrant ahead.
   assign sin_quad  = phase7_ff[PW-1:PW-2];
   assign cos_quad  = sin_quad + 2'd1;
   assign phase_idx = phase7_ff[SINE_TABLE_BITS-1:0];
   assign sin_addr_in = sin_quad[0] ? QUARTER_K - AW'(phase_idx) : AW'(phase_idx);
   assign cos_addr_in = cos_quad[0] ? QUARTER_K - AW'(phase_idx) : AW'(phase_idx);

   // Stage ten: restore the sign of the folded quadrant.
   assign sin_in = sin_neg9_ff ? -SVW'(sin_mag9_ff) : SVW'(sin_mag9_ff);
   assign cos_in = cos_neg9_ff ? -SVW'(cos_mag9_ff) : SVW'(cos_mag9_ff);

   // Datapath registers advance every cycle.
   always_ff @(posedge clock) begin
      mag1_ff      <= mag_in;
      neg1_ff      <= angle[ANGLE_W-1];
      mag2_ff      <= mag1_ff;
      neg2_ff      <= neg1_ff;
      quot2_ff     <= quot_in;
      mag3_ff      <= mag2_ff;
      neg3_ff      <= neg2_ff;
      back3_ff     <= back_in;
      rem4_ff      <= rem_in;
      neg4_ff      <= neg3_ff;
      num5_ff      <= num_in;
      step5_ff     <= step_in;
      neg5_ff      <= neg4_ff;
      pm_est6_ff   <= pm_est_in;
      carry6_ff    <= carry_in;
      neg6_ff      <= neg5_ff;
      phase7_ff    <= phase_in;
      sin_addr8_ff <= sin_addr_in;
      cos_addr8_ff <= cos_addr_in;
      sin_neg8_ff  <= sin_quad[1];
      cos_neg8_ff  <= cos_quad[1];
      sin_mag9_ff  <= SINE_TAB[sin_addr8_ff];
      cos_mag9_ff  <= SINE_TAB[cos_addr8_ff];
      sin_neg9_ff  <= sin_neg8_ff;
      cos_neg9_ff  <= cos_neg8_ff;
      sin10_ff     <= sin_in;
      cos10_ff     <= cos_in;
   end

   assign out_valid = valid_ff[LANE_STAGES-1];
   assign sin_val   = sin10_ff;
   assign cos_val   = cos10_ff;

`ifndef SYNTHESIS
   // The corrected remainder always lies within one turn.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> rem4_ff < TURN_K)
      else $error("lane remainder is not below a full turn");

   // The rounded phase magnitude never exceeds half a turn.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> (pm_est6_ff + PW'(carry6_ff)) <= HALF_STEPS_K)
      else $error("lane phase magnitude beyond half a turn");

   // Folded table addresses stay within the quarter wave.
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[7] |-> (sin_addr8_ff <= QUARTER_K && cos_addr8_ff <= QUARTER_K))
      else $error("lane table address beyond the quarter wave");
`endif

endmodule

### design/e2q_merge.sv
module e2q_merge #(
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [OUT_FRAC_BITS+1:0]    pitch_sin,
   input  logic signed [OUT_FRAC_BITS+1:0]    pitch_cos,
   input  logic signed [OUT_FRAC_BITS+1:0]    yaw_sin,
   input  logic signed [OUT_FRAC_BITS+1:0]    yaw_cos,
   input  logic signed [OUT_FRAC_BITS+1:0]    roll_sin,
   input  logic signed [OUT_FRAC_BITS+1:0]    roll_cos,
   output logic                               out_valid,
   output logic signed [e2q_pkg::OUT_W-1:0]   quat_x,
   output logic signed [e2q_pkg::OUT_W-1:0]   quat_y,
   output logic signed [e2q_pkg::OUT_W-1:0]   quat_z,
   output logic signed [e2q_pkg::OUT_W-1:0]   quat_w
);
   import e2q_pkg::*;

   localparam int SVW   = OUT_FRAC_BITS + 2;
   localparam int PRW   = 2 * SVW;
   localparam int SUMW  = SVW + 1;
   localparam int EXT_W = (SUMW > OUT_W) ? SUMW : OUT_W;

   // Roll and pitch pairs, and the yaw factor each is multiplied by.
   localparam int PAIRS     = 4;
   localparam int PAIR_CRSP = 0;
   localparam int PAIR_SRCP = 1;
   localparam int PAIR_CRCP = 2;
   localparam int PAIR_SRSP = 3;
   localparam int YAW_SIN   = 0;
   localparam int YAW_COS   = 1;
   localparam int TERMS     = 2 * PAIRS;

   localparam logic signed [SVW-1:0]  ONE_K        = SVW'(1 << OUT_FRAC_BITS);
   localparam logic signed [PRW-1:0]  ROUND_HALF_K = PRW'(1 << (OUT_FRAC_BITS - 1));
   localparam logic signed [SUMW-1:0] SAT_HI       = SUMW'((1 << OUT_FRAC_BITS) - 1);
   localparam logic signed [SUMW-1:0] SAT_LO       = SUMW'(-(1 << OUT_FRAC_BITS));

   // Product rescaled by the output fraction, rounding half away from zero.
   function automatic logic signed [SVW-1:0] qround(input logic signed [PRW-1:0] p);
      logic signed [PRW-1:0] bias;
      logic signed [PRW-1:0] acc;
      bias = p[PRW-1] ? ROUND_HALF_K - PRW'(1) : ROUND_HALF_K;
      acc  = p + bias;
      return SVW'(acc >>> OUT_FRAC_BITS);
   endfunction

   // Clamp to the output range, then keep the low bits of the sign-extended value.
   function automatic logic [OUT_W-1:0] saturate(input logic signed [SUMW-1:0] s);
      logic signed [SUMW-1:0]  c;
      logic signed [EXT_W-1:0] e;
      c = s;
      if (s > SAT_HI) begin
         c = SAT_HI;
      end
      if (s < SAT_LO) begin
         c = SAT_LO;
      end
      e = EXT_W'(c);
      return e[OUT_W-1:0];
   endfunction

   logic [MERGE_STAGES-1:0] valid_ff;
   logic [MERGE_STAGES-1:0] valid_in;

   logic signed [PRW-1:0]  pair_raw_in [PAIRS];
   logic signed [PRW-1:0]  pair_raw_ff [PAIRS];
   logic signed [SVW-1:0]  pair_ff [PAIRS];
   logic signed [SVW-1:0]  yaw_sin1_ff, yaw_cos1_ff, yaw_sin2_ff, yaw_cos2_ff;
   logic signed [PRW-1:0]  tri_raw_ff [TERMS];
   logic signed [SVW-1:0]  tri_ff [TERMS];
   logic signed [SUMW-1:0] sum_x, sum_y, sum_z, sum_w;
   logic signed [OUT_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   // Valid bits follow each transfer through the merge.
   assign valid_in = {valid_ff[MERGE_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Roll and pitch products.
   assign pair_raw_in[PAIR_CRSP] = roll_cos * pitch_sin;
   assign pair_raw_in[PAIR_SRCP] = roll_sin * pitch_cos;
   assign pair_raw_in[PAIR_CRCP] = roll_cos * pitch_cos;
   assign pair_raw_in[PAIR_SRSP] = roll_sin * pitch_sin;

   // Quaternion components from the rounded triple products.
   assign sum_x = SUMW'(tri_ff[2*PAIR_CRSP+YAW_SIN]) - SUMW'(tri_ff[2*PAIR_SRCP+YAW_COS]);
   assign sum_y = -SUMW'(tri_ff[2*PAIR_CRSP+YAW_COS]) - SUMW'(tri_ff[2*PAIR_SRCP+YAW_SIN]);
   assign sum_z = SUMW'(tri_ff[2*PAIR_CRCP+YAW_SIN]) - SUMW'(tri_ff[2*PAIR_SRSP+YAW_COS]);
   assign sum_w = SUMW'(tri_ff[2*PAIR_CRCP+YAW_COS]) + SUMW'(tri_ff[2*PAIR_SRSP+YAW_SIN]);

   // Five stages: pair product, round, triple product, round, sum and saturate.
   always_ff @(posedge clock) begin
      yaw_sin1_ff <= yaw_sin;
      yaw_cos1_ff <= yaw_cos;
      yaw_sin2_ff <= yaw_sin1_ff;
      yaw_cos2_ff <= yaw_cos1_ff;
      for (int i = 0; i < PAIRS; i++) begin
         pair_raw_ff[i]                <= pair_raw_in[i];
         pair_ff[i]                    <= qround(pair_raw_ff[i]);
         tri_raw_ff[2*i+YAW_SIN]       <= pair_ff[i] * yaw_sin2_ff;
         tri_raw_ff[2*i+YAW_COS]       <= pair_ff[i] * yaw_cos2_ff;
      end
      for (int k = 0; k < TERMS; k++) begin
         tri_ff[k] <= qround(tri_raw_ff[k]);
      end
      qx_ff <= saturate(sum_x);
      qy_ff <= saturate(sum_y);
      qz_ff <= saturate(sum_z);
      qw_ff <= saturate(sum_w);
   end

   assign out_valid = valid_ff[MERGE_STAGES-1];
   assign quat_x    = qx_ff;
   assign quat_y    = qy_ff;
   assign quat_z    = qz_ff;
   assign quat_w    = qw_ff;

`ifndef SYNTHESIS
   // A result only leaves the merge for a transfer that entered it.
   a_merge_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, MERGE_STAGES))
      else $error("merge result without a matching transfer");

   // Rounded pair products of unit factors stay within plus or minus one.
   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (pair_ff[PAIR_CRSP] <= ONE_K && pair_ff[PAIR_CRSP] >= -ONE_K &&
                       pair_ff[PAIR_SRCP] <= ONE_K && pair_ff[PAIR_SRCP] >= -ONE_K &&
                       pair_ff[PAIR_CRCP] <= ONE_K && pair_ff[PAIR_CRCP] >= -ONE_K &&
                       pair_ff[PAIR_SRSP] <= ONE_K && pair_ff[PAIR_SRSP] >= -ONE_K))
      else $error("pair product beyond unit magnitude");

   // The same holds for the two triple products that form the w component.
   a_triple_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (tri_ff[2*PAIR_CRCP+YAW_COS] <= ONE_K &&
                       tri_ff[2*PAIR_CRCP+YAW_COS] >= -ONE_K &&
                       tri_ff[2*PAIR_SRSP+YAW_SIN] <= ONE_K &&
                       tri_ff[2*PAIR_SRSP+YAW_SIN] >= -ONE_K))
      else $error("triple product beyond unit magnitude");
`endif

endmodule

### design/euler_to_quaternion_core.sv
// Euler angle to quaternion converter, fully pipelined.
// Pipeline: a start transfer reaches the rsp_valid strobe through ten register stages per angle
// lane, including the registered table read, and then five merge stages.
// Throughput: one item per cycle; busy is high only while reset is asserted.
// Reset is synchronous and clears the valid pipeline only; results cannot be stalled.
module euler_to_quaternion_core #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int OUT_FRAC_BITS   = 15,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [e2q_pkg::ANGLE_W-1:0] req_pitch_angle,
   input  logic signed [e2q_pkg::ANGLE_W-1:0] req_yaw_angle,
   input  logic signed [e2q_pkg::ANGLE_W-1:0] req_roll_angle,
   output logic                               rsp_valid,
   output logic signed [e2q_pkg::OUT_W-1:0]   rsp_quat_x,
   output logic signed [e2q_pkg::OUT_W-1:0]   rsp_quat_y,
   output logic signed [e2q_pkg::OUT_W-1:0]   rsp_quat_z,
   output logic signed [e2q_pkg::OUT_W-1:0]   rsp_quat_w
);
   import e2q_pkg::*;

   localparam int SVW = OUT_FRAC_BITS + 2;

   logic                   accept;
   logic signed [ANGLE_W-1:0] angle [LANES];
   logic signed [SVW-1:0]  sin_val [LANES];
   logic signed [SVW-1:0]  cos_val [LANES];
   logic [LANES-1:0]       lane_valid;

   // Requests are taken every cycle outside reset.
   assign busy   = reset;
   assign accept = start & ~busy;

   assign angle[LANE_PITCH] = req_pitch_angle;
   assign angle[LANE_YAW]   = req_yaw_angle;
   assign angle[LANE_ROLL]  = req_roll_angle;

   // One sine and cosine lane per angle.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      e2q_lane #(
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
         .OUT_FRAC_BITS   (OUT_FRAC_BITS),
         .SINE_TABLE_BITS (SINE_TABLE_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .angle     (angle[g]),
         .out_valid (lane_valid[g]),
         .sin_val   (sin_val[g]),
         .cos_val   (cos_val[g])
      );
   end

   // Triple products and output saturation.
   e2q_merge #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (&lane_valid),
      .pitch_sin (sin_val[LANE_PITCH]),
      .pitch_cos (cos_val[LANE_PITCH]),
      .yaw_sin   (sin_val[LANE_YAW]),
      .yaw_cos   (cos_val[LANE_YAW]),
      .roll_sin  (sin_val[LANE_ROLL]),
      .roll_cos  (cos_val[LANE_ROLL]),
      .out_valid (rsp_valid),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z),
      .quat_w    (rsp_quat_w)
   );

`ifndef SYNTHESIS
   // Every response strobe answers a request transfer taken a fixed time earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LATENCY))
      else $error("response strobe without a matching request transfer");

   // The three lanes move in lockstep.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (lane_valid == '0 || lane_valid == '1))
      else $error("angle lanes out of step");

   // A request transfer always produces a response strobe after the pipeline latency.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY (rsp_valid || reset))
      else $error("request transfer lost in the pipeline");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import e2q_pkg::*;

   localparam int ANGLE_FRAC = 8;
   localparam int OUT_FRAC   = 15;
   localparam int TABLE_BITS = 10;

   localparam longint unsigned TURN_UNITS = longint'(DEG_TURN) << ANGLE_FRAC;
   localparam longint unsigned HALF_UNITS = longint'(DEG_HALF_TURN) << ANGLE_FRAC;
   localparam longint unsigned QUARTER    = 64'd1 << TABLE_BITS;
   localparam longint unsigned PHASE_MASK = (QUARTER << 2) - 1;
   localparam longint          ONE_Q      = 64'sd1 << OUT_FRAC;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
      logic signed [OUT_W-1:0] w;
   } quat_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] pitch;
      logic [ANGLE_W-1:0] yaw;
      logic [ANGLE_W-1:0] roll;
      bit                 typed;
      quat_type           want;
   } angle_row_type;

   localparam quat_type IDENTITY = '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF};
   localparam quat_type NO_QUAT  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};

   // Directed rows: the first eight carry results read straight off the maths
   // (whole turns reduce to zero, and a half turn on one axis gives a single
   // component at full scale); the remainder are left to the predictor.
   angle_row_type directed_rows [0:19] = '{
      '{32'd0, 32'd0, 32'd0, 1'b1, IDENTITY},
      '{32'd92160, 32'd92160, 32'd92160, 1'b1, IDENTITY},
      '{-32'sd92160, -32'sd92160, -32'sd92160, 1'b1, IDENTITY},
      '{32'd184320, -32'sd276480, 32'd921600, 1'b1, IDENTITY},
      '{32'd0, 32'd0, 32'd46080, 1'b1, '{16'h8000, 16'h0000, 16'h0000, 16'h0000}},
      '{32'd46080, 32'd0, 32'd0, 1'b1, '{16'h0000, 16'h8000, 16'h0000, 16'h0000}},
      '{32'd0, 32'd46080, 32'd0, 1'b1, '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000}},
      '{32'd0, 32'd0, -32'sd46080, 1'b1, '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000}},
      '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, NO_QUAT},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, NO_QUAT},
      '{32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 1'b0, NO_QUAT},
      '{32'd22, 32'd23, -32'sd23, 1'b0, NO_QUAT},
      '{32'd23040, 32'd23040, 32'd23040, 1'b0, NO_QUAT},
      '{-32'sd23040, 32'd11520, 32'd69120, 1'b0, NO_QUAT},
      '{32'h80000000, 32'h7FFFFFFF, 32'd0, 1'b0, NO_QUAT},
      '{32'd138240, -32'sd138240, 32'd92161, 1'b0, NO_QUAT},
      '{32'd92159, -32'sd92159, 32'd45, 1'b0, NO_QUAT},
      '{32'h12345678, 32'hEDCBA988, 32'h5A5A5A5A, 1'b0, NO_QUAT},
      '{32'd11520, 32'd11520, 32'd11520, 1'b0, NO_QUAT},
      '{32'h7FFFFFFF, 32'h80000000, 32'h80000001, 1'b0, NO_QUAT}
   };

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [ANGLE_W-1:0] req_pitch_angle;
   logic signed [ANGLE_W-1:0] req_yaw_angle;
   logic signed [ANGLE_W-1:0] req_roll_angle;
   logic                      rsp_valid;
   logic signed [OUT_W-1:0]   rsp_quat_x;
   logic signed [OUT_W-1:0]   rsp_quat_y;
   logic signed [OUT_W-1:0]   rsp_quat_z;
   logic signed [OUT_W-1:0]   rsp_quat_w;

   quat_type quat_due [$];
   int       mismatch_count = 0;
   int       burst_left     = 0;

   euler_to_quaternion_core #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC),
      .OUT_FRAC_BITS  (OUT_FRAC),
      .SINE_TABLE_BITS(TABLE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle  (req_yaw_angle),
      .req_roll_angle (req_roll_angle),
      .rsp_valid      (rsp_valid),
      .rsp_quat_x     (rsp_quat_x),
      .rsp_quat_y     (rsp_quat_y),
      .rsp_quat_z     (rsp_quat_z),
      .rsp_quat_w     (rsp_quat_w)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Quarter-wave sine entry k, built from a Q30 Taylor series with rounded
   // products and divisions, then narrowed to the output format.
   function automatic longint sine_entry(input longint unsigned k);
      longint unsigned x, x2, term, d;
      longint acc;
      int sh;
      x = (k * HALF_PI_Q30 + (QUARTER >> 1)) >> TABLE_BITS;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         d = longint'(2 * n) * longint'(2 * n + 1);
         term = (term * x2 + (64'd1 << 29)) >> 30;
         term = (term + d / 2) / d;
         if (n % 2 == 1)
            acc = acc - longint'(term);
         else
            acc = acc + longint'(term);
      end
      if (acc < 0)
         acc = 0;
      if (acc > (64'sd1 << 30))
         acc = 64'sd1 << 30;
      sh = 30 - OUT_FRAC;
      if (sh > 0)
         acc = longint'((longint'(unsigned'(acc)) + (64'd1 << (sh - 1))) >> sh);
      if (acc > ONE_Q)
         acc = ONE_Q;
      return acc;
   endfunction

   // Sine of a phase, using the symmetry of the four quadrants.
   function automatic longint phase_sine(input longint unsigned p);
      longint unsigned quad, idx;
      longint v;
      quad = (p & PHASE_MASK) >> TABLE_BITS;
      idx = p & (QUARTER - 1);
      v = quad[0] ? sine_entry(QUARTER - idx) : sine_entry(idx);
      return quad[1] ? -v : v;
   endfunction

   // Signed angle to the phase of its half angle, rounded half away from zero.
   function automatic longint unsigned half_turn_phase(input logic [ANGLE_W-1:0] a);
      longint unsigned mag, rem, pm;
      mag = {32'd0, a[ANGLE_W-1] ? (32'd0 - a) : a};
      rem = mag % TURN_UNITS;
      pm = (rem * (QUARTER << 1) + HALF_UNITS) / TURN_UNITS;
      return a[ANGLE_W-1] ? ((PHASE_MASK + 1) - pm) & PHASE_MASK : pm & PHASE_MASK;
   endfunction

   function automatic longint fix_mul(input longint a, input longint b);
      longint prod;
      longint unsigned mag;
      prod = a * b;
      mag = (prod < 0) ? longint'(unsigned'(-prod)) : longint'(unsigned'(prod));
      mag = (mag + (64'd1 << (OUT_FRAC - 1))) >> OUT_FRAC;
      return (prod < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_unit(input longint v);
      if (v > ONE_Q - 1)
         v = ONE_Q - 1;
      if (v < -ONE_Q)
         v = -ONE_Q;
      return v[OUT_W-1:0];
   endfunction

   // Quaternion from pitch, yaw and roll with this block's sign convention.
   function automatic quat_type predict_quat(input logic [ANGLE_W-1:0] pitch,
                                             input logic [ANGLE_W-1:0] yaw,
                                             input logic [ANGLE_W-1:0] roll);
      longint unsigned pp, py, pr;
      longint sp, cp, sy, cy, sr, cr;
      quat_type q;
      pp = half_turn_phase(pitch);
      py = half_turn_phase(yaw);
      pr = half_turn_phase(roll);
      sp = phase_sine(pp);
      cp = phase_sine(pp + QUARTER);
      sy = phase_sine(py);
      cy = phase_sine(py + QUARTER);
      sr = phase_sine(pr);
      cr = phase_sine(pr + QUARTER);
      q.x = clamp_unit(fix_mul(fix_mul(cr, sp), sy) - fix_mul(fix_mul(sr, cp), cy));
      q.y = clamp_unit(-fix_mul(fix_mul(cr, sp), cy) - fix_mul(fix_mul(sr, cp), sy));
      q.z = clamp_unit(fix_mul(fix_mul(cr, cp), sy) - fix_mul(fix_mul(sr, sp), cy));
      q.w = clamp_unit(fix_mul(fix_mul(cr, cp), cy) + fix_mul(fix_mul(sr, sp), sy));
      return q;
   endfunction

   // Angles: full-range noise, everyday angles, values close to whole turns,
   // and the extremes of the field.
   function automatic logic [ANGLE_W-1:0] pick_angle();
      int unsigned sel;
      int turns;
      logic [ANGLE_W-1:0] a;
      sel = $urandom_range(99);
      if (sel < 40) begin
         a = $urandom();
      end else if (sel < 70) begin
         a = int'($urandom_range(368640)) - 184320;
      end else if (sel < 85) begin
         turns = int'($urandom_range(46600)) - 23300;
         a = turns * 92160 + int'($urandom_range(60)) - 30;
      end else begin
         case ($urandom_range(5))
            0: a = 32'h80000000;
            1: a = 32'h7FFFFFFF;
            2: a = 32'h00000000;
            3: a = 32'hFFFFFFFF;
            4: a = 32'h00000001;
            default: a = 32'h80000001;
         endcase
      end
      return a;
   endfunction

   // Idle cycles before the next transfer: mostly short, a few long, and now
   // and then a burst with none at all.
   function automatic int pick_gap();
      int unsigned sel;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      sel = $urandom_range(99);
      if (sel < 3) begin
         burst_left = $urandom_range(40, 20);
         return 0;
      end
      if (sel < 45)
         return 0;
      if (sel < 85)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // One request transfer; the expectation is queued once it has been taken.
   task automatic send_angles(input logic [ANGLE_W-1:0] pitch,
                              input logic [ANGLE_W-1:0] yaw,
                              input logic [ANGLE_W-1:0] roll,
                              input bit typed, input quat_type want);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      req_roll_angle  <= roll;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      quat_due.push_back(typed ? want : predict_quat(pitch, yaw, roll));
   endtask

   task automatic compare_field(input string name, input logic signed [OUT_W-1:0] want,
                                input logic signed [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Results are sampled mid-cycle, clear of the edge that retires them.
   always @(negedge clock) begin
      quat_type want;
      if (rsp_valid === 1'b1) begin
         if (quat_due.size() == 0) begin
            $error("rsp_valid with no request transfer outstanding");
            mismatch_count++;
         end else begin
            want = quat_due.pop_front();
            compare_field("quat_x", want.x, rsp_quat_x);
            compare_field("quat_y", want.y, rsp_quat_y);
            compare_field("quat_z", want.z, rsp_quat_z);
            compare_field("quat_w", want.w, rsp_quat_w);
         end
      end
   end

   // Stimulus: reset, the directed rows, then random requests.
   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_pitch_angle <= '0;
      req_yaw_angle   <= '0;
      req_roll_angle  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_angles(directed_rows[i].pitch, directed_rows[i].yaw, directed_rows[i].roll,
                     directed_rows[i].typed, directed_rows[i].want);
      repeat (400)
         send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, NO_QUAT);
      start <= 1'b0;
      while (quat_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### euler_to_quaternion_core.f
design/e2q_pkg.sv
design/e2q_lane.sv
design/e2q_merge.sv
design/euler_to_quaternion_core.sv
test/tb.sv
